@@ rtl/core/dfq_pkg.sv @@
// Shared types and constants of the four-wide decode queue.
`timescale 1ns / 1ps
`default_nettype none

package dfq_pkg;

  // Number of write lanes and of read lanes.
  localparam int unsigned LANES = 4;
  // Width of a payload field on the ports.
  localparam int unsigned DATA_W = 64;
  // Width of the pop count field.
  localparam int unsigned POP_W = 3;
  // Width of the free slot field.
  localparam int unsigned FREE_W = 5;

  // Defaults of the top level parameters.
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_ENTRY_WIDTH = 64;

  typedef struct packed {
    logic              flush;
    logic [POP_W-1:0]  pop_num;
    logic              stalled;
    logic              write_valid_0;
    logic [DATA_W-1:0] write_data_0;
    logic              write_valid_1;
    logic [DATA_W-1:0] write_data_1;
    logic              write_valid_2;
    logic [DATA_W-1:0] write_data_2;
    logic              write_valid_3;
    logic [DATA_W-1:0] write_data_3;
  } in_item_t;

  typedef struct packed {
    logic              out_valid_0;
    logic [DATA_W-1:0] out_data_0;
    logic              out_valid_1;
    logic [DATA_W-1:0] out_data_1;
    logic              out_valid_2;
    logic [DATA_W-1:0] out_data_2;
    logic              out_valid_3;
    logic [DATA_W-1:0] out_data_3;
    logic [FREE_W-1:0] free_slots;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/dfq_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface dfq_in_if;
  import dfq_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dfq_out_if;
  import dfq_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dfq_store.sv @@
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dfq_store import dfq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned ENTRY_WIDTH = DEF_ENTRY_WIDTH,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AW-1:0]          waddr_i,
  input  wire logic [ENTRY_WIDTH-1:0] wdata_i,
  input  wire logic                   re_i,
  input  wire logic [AW-1:0]          raddr_i,
  output      logic [ENTRY_WIDTH-1:0] rdata_o
);

  logic [ENTRY_WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [ENTRY_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/dfq_seq.sv @@
// Sequencer: pointers, occupancy and the per-lane read and write steps.
`timescale 1ns / 1ps
`default_nettype none

module dfq_seq import dfq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned ENTRY_WIDTH = DEF_ENTRY_WIDTH,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire in_item_t               in_item_i,
  output      logic                   in_ready_o,
  output      logic                   res_valid_o,
  output      out_item_t              res_item_o,
  input  wire logic                   res_ready_i,
  output      logic                   mem_we_o,
  output      logic [AW-1:0]          mem_waddr_o,
  output      logic [ENTRY_WIDTH-1:0] mem_wdata_o,
  output      logic                   mem_re_o,
  output      logic [AW-1:0]          mem_raddr_o,
  input  wire logic [ENTRY_WIDTH-1:0] mem_rdata_i
);

  localparam int unsigned LW = $clog2(LANES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WORK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [CW-1:0]     occ_q, occ_d;
  logic [LW-1:0]     lane_q, lane_d;
  logic [LANES-1:0]  offer_q, offer_d;
  logic [LANES-1:0]  wv_q;
  logic [ENTRY_WIDTH-1:0] wd_q [LANES];
  logic [ENTRY_WIDTH-1:0] rd_q [LANES-1];

  logic [CW-1:0]     pop_ext;
  logic [CW-1:0]     pop_eff;
  logic [CW-1:0]     remain;
  logic              accept;
  logic              full;
  logic              do_write;
  logic [CW+4:0]     free_wide;
  logic [LANES-1:0]  in_wv;
  logic [DATA_W-1:0] lane_data [LANES];

  // Sum of an index and a small step, brought back into the queue range.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] idx,
                                             input logic [AW:0]   step);
    logic [AW:0] sum;
    sum = (AW+1)'(idx) + step;
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign accept  = (state_q == ST_IDLE) && in_valid_i;
  assign pop_ext = CW'(in_item_i.pop_num);
  assign pop_eff = (pop_ext > occ_q) ? occ_q : pop_ext;
  assign remain  = occ_q - pop_eff;
  assign full    = (occ_q == CW'(QUEUE_DEPTH));
  assign in_wv   = {in_item_i.write_valid_3, in_item_i.write_valid_2,
                    in_item_i.write_valid_1, in_item_i.write_valid_0};

  // Lane k reads head + k and writes the tail in the same cycle. Offered reads
  // lie inside the occupancy and writes outside it, so they never meet a write.
  assign do_write    = (state_q == ST_WORK) && wv_q[lane_q] && !full;
  assign mem_we_o    = do_write;
  assign mem_waddr_o = tail_q;
  assign mem_wdata_o = wd_q[lane_q];
  assign mem_re_o    = (state_q == ST_WORK);
  assign mem_raddr_o = wrap_add(head_q, (AW+1)'(lane_q));

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    occ_d   = occ_q;
    lane_d  = lane_q;
    offer_d = offer_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.flush) begin
            head_d  = '0;
            tail_d  = '0;
            occ_d   = '0;
            offer_d = '0;
            state_d = ST_DONE;
          end else begin
            head_d = wrap_add(head_q, (AW+1)'(pop_eff));
            occ_d  = remain;
            for (int k = 0; k < LANES; k++) begin
              offer_d[k] = !in_item_i.stalled && (remain > CW'(k));
            end
            lane_d  = '0;
            state_d = ST_WORK;
          end
        end
      end
      ST_WORK: begin
        if (do_write) begin
          tail_d = wrap_add(tail_q, (AW+1)'(1));
          occ_d  = occ_q + CW'(1);
        end
        if (lane_q == LW'(LANES - 1)) begin
          state_d = ST_DONE;
        end else begin
          lane_d = lane_q + LW'(1);
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      lane_q  <= '0;
      offer_q <= '0;
      wv_q    <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      lane_q  <= lane_d;
      offer_q <= offer_d;
      if (accept) begin
        wv_q <= in_wv;
      end
    end
  end

  // Write payloads are latched at acceptance; the read data of lane k is
  // taken from the store output while lane k + 1 is read, and the last lane
  // is read straight from the store, whose output holds once the reads stop.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wd_q[0] <= ENTRY_WIDTH'(in_item_i.write_data_0);
      wd_q[1] <= ENTRY_WIDTH'(in_item_i.write_data_1);
      wd_q[2] <= ENTRY_WIDTH'(in_item_i.write_data_2);
      wd_q[3] <= ENTRY_WIDTH'(in_item_i.write_data_3);
    end
    if ((state_q == ST_WORK) && (lane_q != '0)) begin
      rd_q[lane_q - LW'(1)] <= mem_rdata_i;
    end
  end

  always_comb begin
    for (int k = 0; k < LANES - 1; k++) begin
      lane_data[k] = offer_q[k] ? DATA_W'(rd_q[k]) : '0;
    end
    lane_data[LANES-1] = offer_q[LANES-1] ? DATA_W'(mem_rdata_i) : '0;
  end

  assign free_wide = (CW+5)'(QUEUE_DEPTH) - (CW+5)'(occ_q);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_item_o.out_valid_0 = offer_q[0];
    res_item_o.out_data_0  = lane_data[0];
    res_item_o.out_valid_1 = offer_q[1];
    res_item_o.out_data_1  = lane_data[1];
    res_item_o.out_valid_2 = offer_q[2];
    res_item_o.out_data_2  = lane_data[2];
    res_item_o.out_valid_3 = offer_q[3];
    res_item_o.out_data_3  = lane_data[3];
    res_item_o.free_slots  = free_wide[FREE_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/four_wide_decode_queue.sv @@
// Top level of the four-wide decode queue with its result register.
//
//   Channel  Direction  Transaction
//   in_i     sink       flush, pop count, stall flag and four write lanes
//   out_o    source     four offered head entries and the free slot count
//
// An item is accepted with its pop applied, then the sequencer steps through
// the four lanes on the single read port and single write port of the entry
// store, then hands the result to the output register once it can take it.
// A flush skips the lanes. Reset clears the pointers, occupancy and control
// state but not the store, whose contents stay undefined until written. A
// result waits in the output register while the next item is already accepted.
`timescale 1ns / 1ps
`default_nettype none

module four_wide_decode_queue import dfq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  dfq_in_if.sink     in_i,
  dfq_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic                   res_valid;
  logic                   res_ready;
  out_item_t              res_item;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [ENTRY_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [ENTRY_WIDTH-1:0] mem_rdata;

  logic      out_valid_q;
  out_item_t out_item_q;

  dfq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_item_i   (in_i.payload),
    .in_ready_o  (in_i.ready),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  dfq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result when it is empty or when its
  // current transaction completes in the same cycle.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

`default_nettype wire
